### rtl/lca_pkg.sv
// Shared constants, state encoding and address helpers for the tree LCA block.
// No dependencies; used by the channel interfaces and by tree_lca_distance.
`timescale 1ns / 1ps
`default_nettype none

package lca_pkg;

  // Tree size and depth of the power-of-two ancestor table
  localparam int MAX_NODES = 4096;
  localparam int LEVELS    = 12;

  // Payload field width (node ids, heights, distance)
  localparam int FIELD_W = 12;
  localparam logic [FIELD_W-1:0] HEIGHT_MAX = {FIELD_W{1'b1}};

  // Memory geometry
  localparam int HGT_DEPTH = MAX_NODES;
  localparam int HGT_AW    = $clog2(HGT_DEPTH);
  localparam int TAB_DEPTH = MAX_NODES * LEVELS;
  localparam int TAB_AW    = $clog2(TAB_DEPTH);

  // Level counter holds 0..LEVELS
  localparam int LVL_W = $clog2(LEVELS + 1);

  // Request mode codes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_WALK,
    ST_Q_HGT,
    ST_L_HGT,
    ST_L_CMP,
    ST_J_CMP,
    ST_Q_ANC,
    ST_Q_HC,
    ST_EMIT
  } lca_state_e;

  // Ancestor table address of (node, level): node * LEVELS + level
  function automatic logic [TAB_AW-1:0] tab_addr(input logic [FIELD_W-1:0] node,
                                                 input logic [LVL_W-1:0] lvl);
    logic [TAB_AW-1:0] base;
    base = TAB_AW'(node) * TAB_AW'(LEVELS);
    return base + TAB_AW'(lvl);
  endfunction

  // Height memory address of a node
  function automatic logic [HGT_AW-1:0] hgt_addr(input logic [FIELD_W-1:0] node);
    return HGT_AW'(node);
  endfunction

endpackage

`default_nettype wire

### rtl/lca_req_if.sv
// Request channel: valid/ready handshake carrying mode, node_a and node_b.
// Depends on lca_pkg for the field width.
`timescale 1ns / 1ps
`default_nettype none

interface lca_req_if;
  import lca_pkg::*;

  logic               valid;
  logic               ready;
  logic               mode;
  logic [FIELD_W-1:0] node_a;
  logic [FIELD_W-1:0] node_b;

  modport source (output valid, output mode, output node_a, output node_b, input ready);
  modport sink   (input valid, input mode, input node_a, input node_b, output ready);

endinterface

`default_nettype wire

### rtl/lca_rsp_if.sv
// Response channel: valid/ready handshake carrying ancestor and distance.
// Depends on lca_pkg for the field width.
`timescale 1ns / 1ps
`default_nettype none

interface lca_rsp_if;
  import lca_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] ancestor;
  logic [FIELD_W-1:0] distance;

  modport source (output valid, output ancestor, output distance, input ready);
  modport sink   (input valid, input ancestor, input distance, output ready);

endinterface

`default_nettype wire

### rtl/lca_ram.sv
// Generic synchronous RAM: one write port, two read ports, registered read data.
// Read during write to the same address returns the old contents. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lca_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic      [WIDTH-1:0]         rdata0_o,
  output logic      [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read ports
  always_ff @(posedge clk_i) begin
    rdata0_o <= mem_q[raddr0_i];
    rdata1_o <= mem_q[raddr1_i];
  end

endmodule

`default_nettype wire

### rtl/tree_lca_distance.sv
// Lowest common ancestor and path length over a rooted tree held in two RAMs.
// Depends on lca_pkg, lca_req_if, lca_rsp_if and lca_ram.
//
// A load beat (mode 0) stores node_a with parent node_b (a root names itself)
// and must come after its parent's load; it gives no response. A query beat
// (mode 1) returns the lowest common ancestor of node_a and node_b and the
// number of edges between them. One request is processed at a time. A load
// makes one ancestor-table read per level. In a query the depth-equalizing
// lift costs two dependent reads per level (table, then height), the joint
// lift one table read per level, and the joint lift is skipped when one node
// is an ancestor of the other. The response is loaded into an output register
// when the query finishes; a finished query waits only if the previous
// response has not been taken. Memories need no initialization after reset.
`timescale 1ns / 1ps
`default_nettype none

module tree_lca_distance (
  input wire logic clk_i,
  input wire logic rst_ni,
  lca_req_if.sink  req_i,
  lca_rsp_if.source rsp_o
);
  import lca_pkg::*;

  lca_state_e state_q, state_d;

  logic [LVL_W-1:0]   lvl_q, lvl_d;
  logic [FIELD_W-1:0] a_q, a_d;
  logic [FIELD_W-1:0] b_q, b_d;
  logic [FIELD_W-1:0] p_q, p_d;
  logic [FIELD_W-1:0] hb_q, hb_d;      // height of the shallower node
  logic [FIELD_W:0]   hsum_q, hsum_d;  // h(a) + h(b)
  logic [FIELD_W-1:0] c_q, c_d;
  logic [FIELD_W-1:0] hc_q, hc_d;

  // Memory ports
  logic                hgt_we;
  logic [HGT_AW-1:0]   hgt_waddr, hgt_ra0, hgt_ra1;
  logic [FIELD_W-1:0]  hgt_wdata, hgt_rdata0, hgt_rdata1;
  logic                tab_we;
  logic [TAB_AW-1:0]   tab_waddr, tab_ra0, tab_ra1;
  logic [FIELD_W-1:0]  tab_wdata, tab_rdata0, tab_rdata1, tab_rd0;

  // Read-after-write bypass on table port 0 (load walk can hit its own entry)
  logic               byp_hit_q;
  logic [FIELD_W-1:0] byp_data_q;

  // Output register
  logic               out_valid_q;
  logic [FIELD_W-1:0] out_anc_q, out_dist_q;
  logic               out_load;
  logic [FIELD_W+2:0] dist_s;
  logic [FIELD_W-1:0] dist_sat;

  logic               req_ok;
  logic               accept;
  logic [FIELD_W-1:0] a_n, b_n, ha, hbv;

  lca_ram #(.WIDTH(FIELD_W), .DEPTH(HGT_DEPTH)) u_hgt_ram (
    .clk_i    (clk_i),
    .we_i     (hgt_we),
    .waddr_i  (hgt_waddr),
    .wdata_i  (hgt_wdata),
    .raddr0_i (hgt_ra0),
    .raddr1_i (hgt_ra1),
    .rdata0_o (hgt_rdata0),
    .rdata1_o (hgt_rdata1)
  );

  lca_ram #(.WIDTH(FIELD_W), .DEPTH(TAB_DEPTH)) u_tab_ram (
    .clk_i    (clk_i),
    .we_i     (tab_we),
    .waddr_i  (tab_waddr),
    .wdata_i  (tab_wdata),
    .raddr0_i (tab_ra0),
    .raddr1_i (tab_ra1),
    .rdata0_o (tab_rdata0),
    .rdata1_o (tab_rdata1)
  );

  assign tab_rd0 = byp_hit_q ? byp_data_q : tab_rdata0;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign req_ok      = (32'(req_i.node_a) < 32'(MAX_NODES)) &&
                       (32'(req_i.node_b) < 32'(MAX_NODES));

  // Distance h(a) + h(b) - 2 h(c), clamped to the field range
  assign dist_s   = {2'b00, hsum_q} - {2'b00, hc_q, 1'b0};
  assign dist_sat = dist_s[FIELD_W+2]               ? '0 :
                    (dist_s[FIELD_W+1:FIELD_W] != '0) ? HEIGHT_MAX :
                    dist_s[FIELD_W-1:0];

  // Next state, datapath and memory control
  always_comb begin
    state_d   = state_q;
    lvl_d     = lvl_q;
    a_d       = a_q;
    b_d       = b_q;
    p_d       = p_q;
    hb_d      = hb_q;
    hsum_d    = hsum_q;
    c_d       = c_q;
    hc_d      = hc_q;
    hgt_we    = 1'b0;
    hgt_waddr = '0;
    hgt_wdata = '0;
    hgt_ra0   = '0;
    hgt_ra1   = '0;
    tab_we    = 1'b0;
    tab_waddr = '0;
    tab_wdata = '0;
    tab_ra0   = '0;
    tab_ra1   = '0;
    out_load  = 1'b0;
    a_n       = a_q;
    b_n       = b_q;
    ha        = hgt_rdata0;
    hbv       = hgt_rdata1;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          a_d = req_i.node_a;
          b_d = req_i.node_b;
          if (req_i.mode == MODE_LOAD) begin
            if (req_ok) begin
              // Parent height, level-0 entry, and the parent's level-0 entry
              hgt_ra0   = hgt_addr(req_i.node_b);
              tab_we    = (LEVELS > 0);
              tab_waddr = tab_addr(req_i.node_a, '0);
              tab_wdata = req_i.node_b;
              tab_ra0   = tab_addr(req_i.node_b, '0);
              lvl_d     = LVL_W'(1);
              state_d   = ST_LD_WALK;
            end
          end else if (req_ok) begin
            hgt_ra0 = hgt_addr(req_i.node_a);
            hgt_ra1 = hgt_addr(req_i.node_b);
            state_d = ST_Q_HGT;
          end else begin
            c_d     = '0;
            hc_d    = '0;
            hsum_d  = '0;
            state_d = ST_EMIT;
          end
        end
      end

      ST_LD_WALK: begin
        // Height of the new node, written in the cycle after the parent height read
        if (lvl_q == LVL_W'(1)) begin
          hgt_we    = 1'b1;
          hgt_waddr = hgt_addr(a_q);
          hgt_wdata = (a_q == b_q) ? '0 :
                      (hgt_rdata0 == HEIGHT_MAX) ? HEIGHT_MAX : hgt_rdata0 + 1'b1;
        end
        // entry[l] = up(entry[l-1], l-1); fetch up(entry[l], l) for the next level
        if (int'(lvl_q) < LEVELS) begin
          tab_we    = 1'b1;
          tab_waddr = tab_addr(a_q, lvl_q);
          tab_wdata = tab_rd0;
          tab_ra0   = tab_addr(tab_rd0, lvl_q);
        end
        lvl_d = lvl_q + 1'b1;
        if (int'(lvl_q) + 1 >= LEVELS) begin
          state_d = ST_IDLE;
        end
      end

      ST_Q_HGT: begin
        // Put the deeper node in a
        if (ha < hbv) begin
          a_n  = b_q;
          b_n  = a_q;
          hb_d = ha;
        end else begin
          hb_d = hbv;
        end
        a_d     = a_n;
        b_d     = b_n;
        hsum_d  = {1'b0, ha} + {1'b0, hbv};
        lvl_d   = LVL_W'(LEVELS - 1);
        tab_ra0 = tab_addr(a_n, LVL_W'(LEVELS - 1));
        state_d = ST_L_HGT;
      end

      ST_L_HGT: begin
        p_d     = tab_rd0;
        hgt_ra0 = hgt_addr(tab_rd0);
        state_d = ST_L_CMP;
      end

      ST_L_CMP: begin
        // Lift a while it stays at or below b's depth
        a_n = (hgt_rdata0 >= hb_q) ? p_q : a_q;
        a_d = a_n;
        if (lvl_q == '0) begin
          if (a_n == b_q) begin
            c_d     = b_q;
            hc_d    = hb_q;
            state_d = ST_EMIT;
          end else begin
            tab_ra0 = tab_addr(a_n, LVL_W'(LEVELS - 1));
            tab_ra1 = tab_addr(b_q, LVL_W'(LEVELS - 1));
            lvl_d   = LVL_W'(LEVELS - 1);
            state_d = ST_J_CMP;
          end
        end else begin
          tab_ra0 = tab_addr(a_n, lvl_q - 1'b1);
          lvl_d   = lvl_q - 1'b1;
          state_d = ST_L_HGT;
        end
      end

      ST_J_CMP: begin
        // Joint lift while the ancestors differ
        if (tab_rd0 != tab_rdata1) begin
          a_n = tab_rd0;
          b_n = tab_rdata1;
        end
        a_d = a_n;
        b_d = b_n;
        if (lvl_q == '0) begin
          tab_ra0 = tab_addr(a_n, '0);
          state_d = ST_Q_ANC;
        end else begin
          tab_ra0 = tab_addr(a_n, lvl_q - 1'b1);
          tab_ra1 = tab_addr(b_n, lvl_q - 1'b1);
          lvl_d   = lvl_q - 1'b1;
        end
      end

      ST_Q_ANC: begin
        c_d     = tab_rd0;
        hgt_ra0 = hgt_addr(tab_rd0);
        state_d = ST_Q_HC;
      end

      ST_Q_HC: begin
        hc_d    = hgt_rdata0;
        state_d = ST_EMIT;
      end

      ST_EMIT: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lvl_q       <= '0;
      byp_hit_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      lvl_q     <= lvl_d;
      byp_hit_q <= tab_we && (tab_waddr == tab_ra0);
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    b_q        <= b_d;
    p_q        <= p_d;
    hb_q       <= hb_d;
    hsum_q     <= hsum_d;
    c_q        <= c_d;
    hc_q       <= hc_d;
    byp_data_q <= tab_wdata;
    if (out_load) begin
      out_anc_q  <= c_q;
      out_dist_q <= dist_sat;
    end
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.ancestor = out_anc_q;
  assign rsp_o.distance = out_dist_q;

  // Queries never write the ancestor table
  a_no_tab_write_in_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_Q_HGT || state_q == ST_L_HGT || state_q == ST_L_CMP ||
     state_q == ST_J_CMP || state_q == ST_Q_ANC || state_q == ST_Q_HC ||
     state_q == ST_EMIT) |-> !tab_we)
    else $error("ancestor table written during a query");

  // Height is written once per load, in the cycle after the parent height read
  a_hgt_write_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hgt_we |-> (state_q == ST_LD_WALK && lvl_q == LVL_W'(1) && $past(accept)))
    else $error("height write outside its load slot");

  // Each depth-lift step moves down exactly one level
  a_lift_level_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_L_CMP && lvl_q != '0) |=>
      (state_q == ST_L_HGT && lvl_q == $past(lvl_q) - 1'b1))
    else $error("lift level sequence broken");

  // A new response only comes out of the emit state
  a_rsp_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EMIT))
    else $error("response raised outside emit");

endmodule

`default_nettype wire
